### hdl/bsqrt_pkg.sv
// Package for the bisection square root block: sizes, fixed-point constants,
// the endpoint code and the per-item state record that runs down the cell row.
// No dependencies.
package bsqrt_pkg;

  localparam int unsigned MAX_ITER  = 48;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SQ_W      = 2 * DATA_W;
  localparam int unsigned SC_W      = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W     = $clog2(MAX_ITER + 2);
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned NUM_CELLS = MAX_ITER + 1;

  localparam int unsigned IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [DATA_W-1:0] ONE_FX    = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(6554);

  typedef enum logic [1:0] {
    EP_NONE  = 2'd0,
    EP_LOWER = 2'd1,
    EP_UPPER = 2'd2
  } bsqrt_endpoint_e;

  // Search state of one item. hi/lo bound the band where |x*x - v| is within
  // tolerance, both scaled to the square's fraction bits.
  typedef struct packed {
    logic            done;
    logic            limit;
    bsqrt_endpoint_e endpoint;
    logic [CNT_W-1:0]  n;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] x;
    logic [SC_W-1:0]   v_sc;
    logic [SC_W:0]     hi;
    logic [SC_W-1:0]   lo;
    logic              lo_ok;
  } bsqrt_item_t;

endpackage

### hdl/bsqrt_setup.sv
// Entry stage: registers an accepted radicand together with its initial
// search interval, first midpoint, tolerance band and endpoint flag.
// Depends on bsqrt_pkg.
module bsqrt_setup import bsqrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic              valid_i,
  input  logic [DATA_W-1:0] radicand_i,
  input  logic [DATA_W-1:0] tolerance_i,
  output logic              valid_o,
  output bsqrt_item_t       item_o
);

  logic        valid_q;
  bsqrt_item_t item_d, item_q;

  logic [SC_W-1:0]   v_sc, tol_sc;
  logic [DATA_W-1:0] b_init;

  always_comb begin
    v_sc   = SC_W'(radicand_i) << FRAC_BITS;
    tol_sc = SC_W'(tolerance_i) << FRAC_BITS;
    b_init = (radicand_i > ONE_FX) ? radicand_i : ONE_FX;

    item_d.done  = 1'b0;
    item_d.limit = 1'b0;
    if (radicand_i == '0) begin
      item_d.endpoint = EP_LOWER;
    end else if (radicand_i == ONE_FX) begin
      item_d.endpoint = EP_UPPER;
    end else begin
      item_d.endpoint = EP_NONE;
    end
    item_d.n     = CNT_W'(1);
    item_d.a     = '0;
    item_d.b     = b_init;
    item_d.x     = b_init >> 1;
    item_d.v_sc  = v_sc;
    item_d.hi    = {1'b0, v_sc} + {1'b0, tol_sc};
    item_d.lo    = v_sc - tol_sc;
    item_d.lo_ok = (radicand_i >= tolerance_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/bsqrt_cell.sv
// One bisection step: square the midpoint, then test it against the
// tolerance band and narrow the interval. Two register stages per cell.
// Depends on bsqrt_pkg.
module bsqrt_cell import bsqrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic        valid_i,
  input  bsqrt_item_t item_i,
  output logic        valid_o,
  output bsqrt_item_t item_o
);

  logic        s1_valid_q, s2_valid_q;
  bsqrt_item_t s1_item_q, s2_item_q;
  logic [SQ_W-1:0] sq_d, sq_q;

  logic              outside, above;
  logic [DATA_W:0]   sum_lo, sum_hi;
  bsqrt_item_t       next;

  assign sq_d = SQ_W'(s1_item_q.x) * SQ_W'(s1_item_q.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_item_q <= item_i;
      s2_item_q <= s1_item_q;
      sq_q      <= sq_d;
    end
  end

  always_comb begin
    outside = (sq_q > SQ_W'(s2_item_q.hi)) ||
              (s2_item_q.lo_ok && (sq_q < SQ_W'(s2_item_q.lo)));
    above   = sq_q > SQ_W'(s2_item_q.v_sc);
    // both candidate midpoints, picked once the direction is known
    sum_lo  = {1'b0, s2_item_q.a} + {1'b0, s2_item_q.x};
    sum_hi  = {1'b0, s2_item_q.x} + {1'b0, s2_item_q.b};

    next = s2_item_q;
    if (!s2_item_q.done) begin
      if (!outside) begin
        next.done = 1'b1;
      end else if (s2_item_q.n > CNT_W'(MAX_ITER)) begin
        next.limit = 1'b1;
        next.done  = 1'b1;
      end else if (above) begin
        next.b = s2_item_q.x;
        next.x = sum_lo[DATA_W:1];
        next.n = s2_item_q.n + CNT_W'(1);
      end else begin
        next.a = s2_item_q.x;
        next.x = sum_hi[DATA_W:1];
        next.n = s2_item_q.n + CNT_W'(1);
      end
    end
  end

  assign valid_o = s2_valid_q;
  assign item_o  = next;

endmodule

### hdl/bisection_square_root.sv
// Top level of the bisection square root block: tolerance register, entry
// stage, row of bisection cells and output register.
// Depends on bsqrt_pkg, bsqrt_setup and bsqrt_cell.
//
// Usage:
//   s_axis carries one radicand per item (unsigned fixed point, FRAC_BITS
//   fraction bits). m_axis returns one result per item in arrival order:
//   root and loop count in tdata, endpoint code and limit flag in tuser.
//   cfg writes the tolerance; write it only while no item is in flight.
// Timing:
//   Every item walks the full row of MAX_ITER+1 cells, two register stages
//   each, plus the entry and output registers, the same for every item.
//   Each cell holds its own squarer, so a new item enters every cycle
//   while the output is not stalled.
// Reset:
//   All pipeline valid bits clear; the tolerance returns to 6554 (about 0.1).
// Stall:
//   While a result waits with m_axis_tready low, the whole row holds and
//   s_axis_tready drops; it returns with the cycle that frees the output.
module bisection_square_root import bsqrt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // radicand [31:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // root [31:0], loop_count [37:32], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // endpoint_exact [1:0], limit_reached [2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [DATA_W-1:0]      cfg_data_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o
);

  logic [DATA_W-1:0] tolerance_q;
  logic              advance;

  logic        chain_valid [NUM_CELLS+1];
  bsqrt_item_t chain_item  [NUM_CELLS+1];

  logic        out_valid_q;
  bsqrt_item_t out_item_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tolerance_q <= cfg_data_i;
    end
  end

  bsqrt_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .valid_i     (s_axis_tvalid),
    .radicand_i  (s_axis_tdata[DATA_W-1:0]),
    .tolerance_i (tolerance_q),
    .valid_o     (chain_valid[0]),
    .item_o      (chain_item[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bsqrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (chain_valid[k]),
      .item_i    (chain_item[k]),
      .valid_o   (chain_valid[k+1]),
      .item_o    (chain_item[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= chain_item[NUM_CELLS];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({COUNT_W'(out_item_q.n), out_item_q.x});
  assign m_axis_tuser  = {out_item_q.limit, out_item_q.endpoint};

endmodule

### hdl/bsqrt_checker.sv
// Port-level checks for the bisection square root block, bound to the top.
// Depends on bsqrt_pkg and bisection_square_root.
module bsqrt_checker import bsqrt_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // the row advances exactly when the output is free
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DATA_W+COUNT_W-1:DATA_W] != '0)
    else $error("loop count is zero");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tdata[DATA_W+COUNT_W-1:DATA_W] == COUNT_W'(MAX_ITER + 1))
    else $error("limit flag without full iteration count");

endmodule

bind bisection_square_root bsqrt_checker u_bsqrt_checker (.*);

### test/testbench.sv
// Testbench for bisection_square_root: streams radicands through the block,
// predicts root, loop count and flags in fixed point, and checks each result.
// Depends on bsqrt_pkg and the bisection_square_root top level.
module testbench;
  import bsqrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_ITER + 10;

  typedef struct packed {
    logic [DATA_W-1:0]  root;
    logic [COUNT_W-1:0] loop_count;
    bsqrt_endpoint_e    endpoint;
    logic               limit;
  } root_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_W-1:0]      cfg_data_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;

  root_result_t      pending_roots[$];
  root_result_t      want_q;
  root_result_t      got_q;
  logic [DATA_W-1:0] tolerance_q = TOL_RESET;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;

  bisection_square_root dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Bisect on [0, max(1.0, v)] with exact 64-bit squares; midpoint truncates.
  function automatic root_result_t predict_root(input logic [DATA_W-1:0] v,
                                                input logic [DATA_W-1:0] tol);
    logic [63:0]  v_sc;
    logic [63:0]  tol_sc;
    logic [63:0]  lo_end;
    logic [63:0]  hi_end;
    logic [63:0]  mid;
    logic [63:0]  sq;
    logic [63:0]  err;
    int unsigned  n;
    root_result_t r;
    v_sc = {32'd0, v} << FRAC_BITS;
    tol_sc = {32'd0, tol} << FRAC_BITS;
    lo_end = '0;
    hi_end = (v > ONE_FX) ? {32'd0, v} : {32'd0, ONE_FX};
    mid = (lo_end + hi_end) >> 1;
    n = 1;
    r.limit = 1'b0;
    if (v == '0) begin
      r.endpoint = EP_LOWER;
    end else if (hi_end * hi_end == v_sc) begin
      r.endpoint = EP_UPPER;
    end else begin
      r.endpoint = EP_NONE;
    end
    forever begin
      sq = mid * mid;
      err = (sq > v_sc) ? sq - v_sc : v_sc - sq;
      if (err <= tol_sc) break;
      if (n > MAX_ITER) begin
        r.limit = 1'b1;
        break;
      end
      if (sq > v_sc) begin
        hi_end = mid;
      end else begin
        lo_end = mid;
      end
      mid = (lo_end + hi_end) >> 1;
      n++;
    end
    r.root = mid[DATA_W-1:0];
    r.loop_count = COUNT_W'(n);
    return r;
  endfunction

  // Receiver side: random stall, then compare each accepted result in order.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_q.root = m_axis_tdata[DATA_W-1:0];
      got_q.loop_count = m_axis_tdata[DATA_W +: COUNT_W];
      got_q.endpoint = bsqrt_endpoint_e'(m_axis_tuser[1:0]);
      got_q.limit = m_axis_tuser[2];
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: root %h count %0d endpoint %0d limit %0d",
                   got_q.root, got_q.loop_count, got_q.endpoint, got_q.limit);
      end else begin
        want_q = pending_roots.pop_front();
        if (got_q.root !== want_q.root || got_q.loop_count !== want_q.loop_count ||
            got_q.endpoint !== want_q.endpoint || got_q.limit !== want_q.limit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: root %h/%h count %0d/%0d endpoint %0d/%0d limit %0d/%0d %s",
                     want_q.root, got_q.root, want_q.loop_count, got_q.loop_count,
                     want_q.endpoint, got_q.endpoint, want_q.limit, got_q.limit,
                     "(expected/actual)");
        end
      end
    end
  end

  task automatic send_radicand(input logic [DATA_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata <= v;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_roots.push_back(predict_root(v, tolerance_q));
  endtask

  // Drop valid and hold until every result has come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_roots.size() != 0);
  endtask

  task automatic write_tolerance(input logic [DATA_W-1:0] tol);
    wait_results_drained();
    cfg_data_i <= tol;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tolerance_q = tol;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] random_radicand();
    logic [DATA_W-1:0] k;
    case ($urandom_range(4))
      0: return DATA_W'($urandom_range(0, 32'h1FFFF));
      1: return $urandom & 32'h00FF_FFFF;
      2: begin
        // exact integer squares stop the search early
        k = DATA_W'($urandom_range(0, 255));
        return (k * k) << FRAC_BITS;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_tolerance();
    // zero, one LSB, just below and above one, exact squares, top of range
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0000_FFFF);
    send_radicand(ONE_FX);
    send_radicand(32'h0001_0001);
    send_radicand(32'h0002_0000);
    send_radicand(32'h0004_0000);
    send_radicand(32'h0000_4000);
    send_radicand(32'h5555_5555);
    send_radicand(32'hAAAA_AAAA);
    send_radicand(32'h8000_0000);
    send_radicand(32'hFFFF_0000);
    send_radicand(32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  task automatic test_zero_tolerance();
    write_tolerance('0);
    send_radicand(32'h0000_0000);
    send_radicand(ONE_FX);
    send_radicand(32'h0002_0000);
    send_radicand(32'h0009_0000);
    send_radicand(32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  task automatic test_max_tolerance();
    write_tolerance('1);
    send_radicand(32'h0000_0000);
    send_radicand(ONE_FX);
    send_radicand(32'h0003_0000);
    send_radicand(32'hFFFF_FFFF);
    wait_results_drained();
  endtask

  task automatic test_random_stream(input int unsigned count, input logic [DATA_W-1:0] tol,
                                    input int unsigned idle_pct, input int unsigned hold_pct);
    write_tolerance(tol);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    repeat (count) send_radicand(random_radicand());
    wait_results_drained();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_tolerance();
    test_zero_tolerance();
    test_max_tolerance();
    test_random_stream(165, DATA_W'($urandom_range(1, 32'h1FFFF)), 0, 0);
    test_random_stream(165, '0, 83, 0);
    test_random_stream(165, TOL_RESET, 0, 83);
    test_random_stream(165, $urandom, 23, 23);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
